FILE: rtl/sle_pkg.sv
`timescale 1ns / 1ps

package sle_pkg;

    // list store geometry
    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LEN_W    = $clog2(CAPACITY + 1);

    // port field widths
    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int CNT_OUT_W = 7;

    // compare width wide enough for length, position and one more
    localparam int CMP_W    = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

    // length update codes
    typedef logic [1:0] len_op_t;
    localparam len_op_t LEN_KEEP  = 2'd0;
    localparam len_op_t LEN_CLEAR = 2'd1;
    localparam len_op_t LEN_INC   = 2'd2;
    localparam len_op_t LEN_DEC   = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic    load;         // capture the item's fields
        logic    scan_rd;      // read entry cnt, advance cnt
        logic    sh_init_ins;  // j = length
        logic    sh_init_del;  // j = matched index
        logic    sh_rd;        // read neighbor of j
        logic    sh_wr;        // write j with read data, step j
        logic    wr_val;       // write the item's value
        logic    read_pos;     // read entry position-1
        logic    finish;       // register a result
        logic    res_ok;
        logic    res_rd;       // read_value from store data
        logic    res_found;    // found_position from scan count
        len_op_t len_op;
    } sle_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             ins_ok;
        logic             rd_ok;
        logic             hit;
        logic             scan_more;
        logic             shift_more;
    } sle_stat_t;

endpackage

FILE: rtl/sle_ram.sv
`timescale 1ns / 1ps

module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sle_ctrl.sv
`timescale 1ns / 1ps

module sle_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sle_pkg::sle_stat_t st,
    output sle_pkg::sle_ctl_t  ctl,
    output logic              busy
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DISP    = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_SH_RD   = 3'd3;
    localparam logic [2:0] S_SH_WR   = 3'd4;
    localparam logic [2:0] S_RD_WAIT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctl        = '0;
        ctl.len_op = sle_pkg::LEN_KEEP;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_IDLE;
                unique case (st.cmd)
                    sle_pkg::CMD_CLEAR:
                    begin
                        ctl.finish = 1'b1;
                        ctl.res_ok = 1'b1;
                        ctl.len_op = sle_pkg::LEN_CLEAR;
                    end
                    sle_pkg::CMD_APPEND:
                    begin
                        ctl.finish = 1'b1;
                        if (!st.full)
                        begin
                            ctl.wr_val = 1'b1;
                            ctl.res_ok = 1'b1;
                            ctl.len_op = sle_pkg::LEN_INC;
                        end
                    end
                    sle_pkg::CMD_INSERT:
                    begin
                        if (st.ins_ok)
                        begin
                            ctl.sh_init_ins = 1'b1;
                            state_next      = S_SH_RD;
                        end
                        else
                        begin
                            ctl.finish = 1'b1;
                        end
                    end
                    sle_pkg::CMD_DELETE,
                    sle_pkg::CMD_LOCATE:
                    begin
                        state_next = S_SCAN;
                    end
                    sle_pkg::CMD_READ:
                    begin
                        if (st.rd_ok)
                        begin
                            ctl.read_pos = 1'b1;
                            state_next   = S_RD_WAIT;
                        end
                        else
                        begin
                            ctl.finish = 1'b1;
                        end
                    end
                    default:
                    begin
                        ctl.finish = 1'b1;
                    end
                endcase
            end
            S_SCAN:
            begin
                // one read issued per cycle, compare in the cycle after
                if (st.hit)
                begin
                    if (st.cmd == sle_pkg::CMD_LOCATE)
                    begin
                        ctl.finish    = 1'b1;
                        ctl.res_ok    = 1'b1;
                        ctl.res_found = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        ctl.sh_init_del = 1'b1;
                        state_next      = S_SH_RD;
                    end
                end
                else if (st.scan_more)
                begin
                    ctl.scan_rd = 1'b1;
                end
                else
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SH_RD:
            begin
                if (st.shift_more)
                begin
                    ctl.sh_rd  = 1'b1;
                    state_next = S_SH_WR;
                end
                else
                begin
                    ctl.finish = 1'b1;
                    ctl.res_ok = 1'b1;
                    state_next = S_IDLE;
                    if (st.cmd == sle_pkg::CMD_INSERT)
                    begin
                        ctl.wr_val = 1'b1;
                        ctl.len_op = sle_pkg::LEN_INC;
                    end
                    else
                    begin
                        ctl.len_op = sle_pkg::LEN_DEC;
                    end
                end
            end
            S_SH_WR:
            begin
                ctl.sh_wr  = 1'b1;
                state_next = S_SH_RD;
            end
            S_RD_WAIT:
            begin
                ctl.finish = 1'b1;
                ctl.res_ok = 1'b1;
                ctl.res_rd = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: rtl/sle_dp.sv
`timescale 1ns / 1ps

module sle_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sle_pkg::sle_ctl_t                   ctl,
    output sle_pkg::sle_stat_t                  st,
    input  logic [sle_pkg::CMD_W-1:0]           command,
    input  logic [sle_pkg::POS_W-1:0]           position,
    input  logic signed [sle_pkg::DATA_W-1:0]   value,
    output logic                                done,
    output logic                                ok,
    output logic signed [sle_pkg::DATA_W-1:0]   read_value,
    output logic [sle_pkg::POS_W-1:0]           found_position,
    output logic [sle_pkg::CNT_OUT_W-1:0]       list_count,
    output logic                                is_empty
);

    localparam int AW = sle_pkg::ADDR_W;
    localparam int LW = sle_pkg::LEN_W;
    localparam int CW = sle_pkg::CMP_W;

    logic [sle_pkg::CMD_W-1:0]  cmd_reg;
    logic [sle_pkg::POS_W-1:0]  pos_reg;
    logic [sle_pkg::DATA_W-1:0] val_reg;
    logic [LW-1:0]              len_reg;
    logic [LW-1:0]              len_next;
    logic [LW-1:0]              cnt_reg;
    logic [AW-1:0]              j_reg;
    logic                       rdv_reg;

    logic                          done_reg;
    logic                          ok_reg;
    logic [sle_pkg::DATA_W-1:0]    rdval_reg;
    logic [sle_pkg::POS_W-1:0]     found_reg;
    logic [sle_pkg::CNT_OUT_W-1:0] count_reg;
    logic                          empty_reg;

    logic                       ram_we;
    logic [AW-1:0]              ram_addr;
    logic [sle_pkg::DATA_W-1:0] ram_wdata;
    logic [sle_pkg::DATA_W-1:0] ram_rdata;

    logic                       is_ins;
    logic [AW-1:0]              pos_idx;

    assign is_ins  = (cmd_reg == sle_pkg::CMD_INSERT);
    assign pos_idx = AW'(pos_reg - sle_pkg::POS_W'(1));

    // status
    assign st.cmd       = cmd_reg;
    assign st.full      = (len_reg == LW'(sle_pkg::CAPACITY));
    assign st.ins_ok    = (pos_reg != '0)
                        && (CW'(pos_reg) <= CW'(len_reg) + CW'(1))
                        && !st.full;
    assign st.rd_ok     = (pos_reg != '0) && (CW'(pos_reg) <= CW'(len_reg));
    assign st.hit       = rdv_reg && (ram_rdata == val_reg);
    assign st.scan_more = (cnt_reg < len_reg);
    assign st.shift_more = is_ins ? (CW'(j_reg) >= CW'(pos_reg))
                                  : ((LW'(j_reg) + LW'(1)) < len_reg);

    // store port
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = j_reg;
        ram_wdata = ram_rdata;
        priority if (ctl.scan_rd)
        begin
            ram_addr = AW'(cnt_reg);
        end
        else if (ctl.sh_rd)
        begin
            ram_addr = is_ins ? (j_reg - AW'(1)) : (j_reg + AW'(1));
        end
        else if (ctl.sh_wr)
        begin
            ram_we = 1'b1;
        end
        else if (ctl.wr_val)
        begin
            ram_we    = 1'b1;
            ram_wdata = val_reg;
            ram_addr  = is_ins ? pos_idx : AW'(len_reg);
        end
        else if (ctl.read_pos)
        begin
            ram_addr = pos_idx;
        end
    end

    sle_ram #(
        .WIDTH (sle_pkg::DATA_W),
        .DEPTH (sle_pkg::CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        unique case (ctl.len_op)
            sle_pkg::LEN_KEEP:  len_next = len_reg;
            sle_pkg::LEN_CLEAR: len_next = '0;
            sle_pkg::LEN_INC:   len_next = len_reg + LW'(1);
            sle_pkg::LEN_DEC:   len_next = len_reg - LW'(1);
            default:            len_next = len_reg;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            rdv_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            rdv_reg  <= ctl.scan_rd;
            done_reg <= ctl.finish;
        end
    end

    // item fields, walk counters, result payload
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= command;
            pos_reg <= position;
            val_reg <= value;
            cnt_reg <= '0;
        end
        else if (ctl.scan_rd)
        begin
            cnt_reg <= cnt_reg + LW'(1);
        end

        priority if (ctl.sh_init_ins)
        begin
            j_reg <= AW'(len_reg);
        end
        else if (ctl.sh_init_del)
        begin
            j_reg <= AW'(cnt_reg - LW'(1));
        end
        else if (ctl.sh_wr)
        begin
            j_reg <= is_ins ? (j_reg - AW'(1)) : (j_reg + AW'(1));
        end

        if (ctl.finish)
        begin
            ok_reg    <= ctl.res_ok;
            rdval_reg <= ctl.res_rd ? ram_rdata : '0;
            found_reg <= ctl.res_found ? sle_pkg::POS_W'(cnt_reg) : '0;
            count_reg <= sle_pkg::CNT_OUT_W'(len_next);
            empty_reg <= (len_next == '0);
        end
    end

    assign done           = done_reg;
    assign ok             = ok_reg;
    assign read_value     = rdval_reg;
    assign found_position = found_reg;
    assign list_count     = count_reg;
    assign is_empty       = empty_reg;

endmodule

FILE: rtl/sequential_list_engine.sv
`timescale 1ns / 1ps

// Ordered list of signed words in a single-port store with a length register.
// Clear, append, failed insert and read, and unknown commands finish at dispatch;
// read waits on the store; locate and delete scan from the head, the compare
// trailing each store read; an insert and a hit delete then shift entries one
// at a time. One store access per cycle. Throughput: one item at a time, busy
// from acceptance until the result; the next item is taken on the edge ending done.
// Reset empties the list; store contents are left undefined.
module sequential_list_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [sle_pkg::CMD_W-1:0]           command,
    input  logic [sle_pkg::POS_W-1:0]           position,
    input  logic signed [sle_pkg::DATA_W-1:0]   value,
    output logic                                done,
    output logic                                ok,
    output logic signed [sle_pkg::DATA_W-1:0]   read_value,
    output logic [sle_pkg::POS_W-1:0]           found_position,
    output logic [sle_pkg::CNT_OUT_W-1:0]       list_count,
    output logic                                is_empty
);

    sle_pkg::sle_ctl_t  ctl;
    sle_pkg::sle_stat_t st;

    // sequencer: dispatch, scan, shift walk, read wait
    sle_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .ctl   (ctl),
        .busy  (busy)
    );

    // store, length, walk counters and result registers
    sle_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .st             (st),
        .command        (command),
        .position       (position),
        .value          (value),
        .done           (done),
        .ok             (ok),
        .read_value     (read_value),
        .found_position (found_position),
        .list_count     (list_count),
        .is_empty       (is_empty)
    );

    // a result is issued only once the sequencer is back at rest
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // an accepted item always occupies the engine for the following cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (list_count == '0)))
        else $error("empty flag disagrees with count");

    // a failed command reports neither data nor a position
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> ((read_value == '0) && (found_position == '0)))
        else $error("failed result carries data");

endmodule

FILE: bench/tb_sequential_list_engine.sv
`timescale 1ns / 1ps

// Random traffic mixes commands by mode:
//   filling  - mostly appends and inserts, drives the list up to full
//   churn    - broad mix of all commands, clears and undefined codes rare
//   draining - mostly deletes of values that are present
module tb_sequential_list_engine;

    localparam int CAPACITY  = sle_pkg::CAPACITY;
    localparam int DATA_W    = sle_pkg::DATA_W;
    localparam int CMD_W     = sle_pkg::CMD_W;
    localparam int POS_W     = sle_pkg::POS_W;
    localparam int CNT_OUT_W = sle_pkg::CNT_OUT_W;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = sle_pkg::CMD_CLEAR;
    localparam logic [CMD_W-1:0] CMD_APPEND = sle_pkg::CMD_APPEND;
    localparam logic [CMD_W-1:0] CMD_INSERT = sle_pkg::CMD_INSERT;
    localparam logic [CMD_W-1:0] CMD_DELETE = sle_pkg::CMD_DELETE;
    localparam logic [CMD_W-1:0] CMD_LOCATE = sle_pkg::CMD_LOCATE;
    localparam logic [CMD_W-1:0] CMD_READ   = sle_pkg::CMD_READ;

    // command codes outside the defined set; the block must refuse them
    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    localparam int FILLING  = 0;
    localparam int CHURN    = 1;
    localparam int DRAINING = 2;

    localparam int RANDOM_ITEMS = 600;
    localparam int QUIET_ITEMS  = 100;  // tail of the run with no sender gaps
    localparam int DRAIN_CYCLES = 250;  // idle cycles after the last result is checked

    // one result item as the block reports it
    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic [POS_W-1:0]         found_position;
        logic [CNT_OUT_W-1:0]     list_count;
        logic                     is_empty;
    } list_result_t;

    // directed stimulus row; 'typed' rows carry a hand-written expectation
    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        bit                       typed;
        list_result_t             want;
    } list_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [CMD_W-1:0]         command;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic                     done;
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         found_position;
    logic [CNT_OUT_W-1:0]     list_count;
    logic                     is_empty;

    // shadow copy of the list; entries at and above shadow_len are stale
    logic signed [DATA_W-1:0] shadow_words [CAPACITY];
    int                       shadow_len;

    list_result_t             pending_results [$];
    list_row_t                directed_rows [$];
    int                       mismatches;
    bit                       idle_on;

    // command mix per mode, indexed by command code (weights sum to 100)
    int unsigned              cmd_mix [3][8] = '{
        '{0, 50, 30,  4,  6,  8, 1, 1},
        '{2, 18, 20, 20, 15, 20, 3, 2},
        '{4,  5,  5, 50, 15, 16, 3, 2}
    };

    sequential_list_engine dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .position       (position),
        .value          (value),
        .done           (done),
        .ok             (ok),
        .read_value     (read_value),
        .found_position (found_position),
        .list_count     (list_count),
        .is_empty       (is_empty)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Applies one command to the shadow list and returns what the block
    // should report. Delete and locate both stop at the first equal entry.
    function automatic list_result_t apply_list_command(
        input logic [CMD_W-1:0]         cmd,
        input logic [POS_W-1:0]         pos,
        input logic signed [DATA_W-1:0] val
    );
        list_result_t r;
        int           p;
        int           hit;
        int           i;
        r   = '0;
        p   = int'(pos);
        hit = -1;
        case (cmd)
            CMD_CLEAR:
            begin
                shadow_len = 0;
                r.ok       = 1'b1;
            end
            CMD_APPEND:
                if (shadow_len < CAPACITY)
                begin
                    shadow_words[shadow_len] = val;
                    shadow_len++;
                    r.ok = 1'b1;
                end
            CMD_INSERT:
                if (p >= 1 && p <= shadow_len + 1 && shadow_len < CAPACITY)
                begin
                    for (i = shadow_len; i > p - 1; i--)
                        shadow_words[i] = shadow_words[i - 1];
                    shadow_words[p - 1] = val;
                    shadow_len++;
                    r.ok = 1'b1;
                end
            CMD_DELETE, CMD_LOCATE:
            begin
                for (i = 0; i < shadow_len; i++)
                    if (hit < 0 && shadow_words[i] == val)
                        hit = i;
                if (hit >= 0)
                begin
                    r.ok = 1'b1;
                    if (cmd == CMD_LOCATE)
                        r.found_position = POS_W'(hit + 1);
                    else
                    begin
                        for (i = hit; i + 1 < shadow_len; i++)
                            shadow_words[i] = shadow_words[i + 1];
                        shadow_len--;
                    end
                end
            end
            CMD_READ:
                if (p >= 1 && p <= shadow_len)
                begin
                    r.read_value = shadow_words[p - 1];
                    r.ok         = 1'b1;
                end
            default: ;
        endcase
        r.list_count = CNT_OUT_W'(shadow_len);
        r.is_empty   = (shadow_len == 0);
        return r;
    endfunction

    function automatic int field_mismatch(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic add_row(input logic [CMD_W-1:0] cmd, input int pos, input int val,
                           input bit typed, input bit w_ok, input int w_cnt,
                           input bit w_empty);
        list_row_t row;
        row                     = '0;
        row.cmd                 = cmd;
        row.pos                 = POS_W'(pos);
        row.val                 = val;
        row.typed               = typed;
        row.want.ok             = w_ok;
        row.want.list_count     = CNT_OUT_W'(w_cnt);
        row.want.is_empty       = w_empty;
        directed_rows.push_back(row);
    endtask

    // Presents one item from a falling edge and holds it until accepted.
    // The item may be raised while the block is still busy with the last one,
    // so sender gaps land at varying points of the block's work.
    task automatic issue_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] val, input bit typed,
                              input list_result_t want);
        list_result_t predicted;
        command  <= cmd;
        position <= pos;
        value    <= val;
        start    <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        // accepted at this edge; shadow state moves on now
        predicted = apply_list_command(cmd, pos, val);
        pending_results.push_back(typed ? want : predicted);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    // Values: mostly entries already in the list for searches, otherwise a
    // mix of full-range words, a small pool that makes duplicates, and extremes.
    function automatic logic signed [DATA_W-1:0] pick_value(input bit search);
        if (search && shadow_len > 0 && $urandom_range(0, 9) < 7)
            return shadow_words[$urandom_range(0, shadow_len - 1)];
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 7);
            1:
                case ($urandom_range(0, 3))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7FFF_FFFF;
                    2:       return 32'sh0000_0000;
                    default: return -32'sd1;
                endcase
            default: return $urandom;
        endcase
    endfunction

    task automatic pick_random_item(input int mode, output logic [CMD_W-1:0] cmd,
                                    output logic [POS_W-1:0] pos,
                                    output logic signed [DATA_W-1:0] val);
        int unsigned roll;
        int          c;
        roll = $urandom_range(0, 99);
        cmd  = CMD_CLEAR;
        for (c = 0; c < 8; c++)
        begin
            if (roll < cmd_mix[mode][c])
            begin
                cmd = CMD_W'(c);
                break;
            end
            roll -= cmd_mix[mode][c];
        end
        // positions: for insert and read mostly legal for the current length, else any 7-bit value
        pos = POS_W'($urandom_range(0, 127));
        if (cmd == CMD_INSERT && $urandom_range(0, 99) < 85)
            pos = POS_W'($urandom_range(1, shadow_len + 1));
        else if (cmd == CMD_READ && shadow_len > 0 && $urandom_range(0, 99) < 85)
            pos = POS_W'($urandom_range(1, shadow_len));
        val = pick_value(cmd == CMD_DELETE || cmd == CMD_LOCATE);
    endtask

    // Result checker: done is a one-cycle strobe, compared against the
    // oldest outstanding expectation.
    always @(posedge clk)
    begin : result_check
        list_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result strobe with no item outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                mismatches += field_mismatch("ok", 32'(want.ok), 32'(ok))
                            + field_mismatch("read_value", want.read_value, read_value)
                            + field_mismatch("found_position", 32'(want.found_position),
                                             32'(found_position))
                            + field_mismatch("list_count", 32'(want.list_count),
                                             32'(list_count))
                            + field_mismatch("is_empty", 32'(want.is_empty),
                                             32'(is_empty));
            end
        end
    end

    // Hard stop; the slowest legal run is well under a tenth of this.
    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        int                       mode;
        int                       seg_left;
        int                       n;

        rst_n      = 1'b0;
        start      = 1'b0;
        command    = CMD_CLEAR;
        position   = '0;
        value      = '0;
        mismatches = 0;
        shadow_len = 0;
        idle_on    = 1'b1;

        // Directed table. Typed rows: cmd, pos, value, 1, ok, count, empty
        // (read_value and found_position are zero on all of them).
        // Rows with typed = 0 take the predictor's answer.
        // empty list: every lookup, delete and insert refuses
        add_row(CMD_READ,     1,   0,            1, 0, 0, 1);
        add_row(CMD_LOCATE,   0,   0,            1, 0, 0, 1);
        add_row(CMD_DELETE,   0,   0,            1, 0, 0, 1);
        add_row(CMD_INSERT,   0,   5,            1, 0, 0, 1);  // position zero
        add_row(CMD_INSERT,   2,   5,            1, 0, 0, 1);  // past length+1
        // value extremes
        add_row(CMD_APPEND,   0,   32'h7FFF_FFFF, 1, 1, 1, 0);
        add_row(CMD_APPEND,   127, 32'h8000_0000, 1, 1, 2, 0);
        // insert at head, at length+1 and in the middle
        add_row(CMD_INSERT,   1,   -1,           0, 0, 0, 0);
        add_row(CMD_INSERT,   4,   0,            0, 0, 0, 0);
        add_row(CMD_INSERT,   3,   32'h5555_5555, 0, 0, 0, 0);
        add_row(CMD_READ,     1,   0,            0, 0, 0, 0);
        add_row(CMD_READ,     5,   0,            0, 0, 0, 0);
        // reads outside 1..length
        add_row(CMD_READ,     6,   0,            1, 0, 5, 0);
        add_row(CMD_READ,     0,   0,            1, 0, 5, 0);
        add_row(CMD_READ,     127, 0,            1, 0, 5, 0);
        add_row(CMD_LOCATE,   0,   32'h8000_0000, 0, 0, 0, 0);
        add_row(CMD_LOCATE,   0,   32'hAAAA_AAAA, 1, 0, 5, 0);  // absent
        add_row(CMD_DELETE,   0,   32'h7FFF_FFFF, 0, 0, 0, 0);
        add_row(CMD_DELETE,   0,   32'h1234_5678, 1, 0, 4, 0);  // absent
        // undefined command codes and an insert far past length+1 change nothing
        add_row(CMD_UNUSED_6, 64,  7,            1, 0, 4, 0);
        add_row(CMD_UNUSED_7, 127, -1,           1, 0, 4, 0);
        add_row(CMD_INSERT,   127, 9,            1, 0, 4, 0);
        // clear keeps stale words in the store; they must not show up
        add_row(CMD_CLEAR,    0,   0,            1, 1, 0, 1);
        add_row(CMD_READ,     1,   0,            1, 0, 0, 1);
        add_row(CMD_APPEND,   0,   0,            1, 1, 1, 0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[k])
            issue_item(directed_rows[k].cmd, directed_rows[k].pos, directed_rows[k].val,
                       directed_rows[k].typed, directed_rows[k].want);

        // first segment fills the list so the full cases come up early
        mode     = FILLING;
        seg_left = 100;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (seg_left == 0)
            begin
                mode     = $urandom_range(FILLING, DRAINING);
                seg_left = (mode == FILLING) ? $urandom_range(60, 120)
                                             : $urandom_range(20, 60);
            end
            seg_left--;
            idle_on = (n < RANDOM_ITEMS - QUIET_ITEMS);
            pick_random_item(mode, cmd, pos, val);
            issue_item(cmd, pos, val, 1'b0, '0);
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
